### rtl/core/lnbg_pkg.sv
// Shared types, constants and the microcode table of the nibble-bus display writer.
package lnbg_pkg;

    // Framebuffer geometry.
    localparam int COLUMNS    = 100;
    localparam int PIXEL_ROWS = 16;
    localparam int FB_DEPTH   = 2 * COLUMNS;
    localparam int FB_AW      = $clog2(FB_DEPTH);

    // Microprogram counter width and table depth.
    localparam int UPC_W      = 4;

    // Input command codes.
    localparam logic [2:0] CMD_PIXEL   = 3'd0;
    localparam logic [2:0] CMD_REFRESH = 3'd1;
    localparam logic [2:0] CMD_ZERO    = 3'd2;
    localparam logic [2:0] CMD_CURSOR  = 3'd3;
    localparam logic [2:0] CMD_CHAR    = 3'd4;
    localparam logic [2:0] CMD_CMDBYTE = 3'd5;
    localparam logic [2:0] CMD_NIBBLE  = 3'd6;

    // Display command prefixes.
    localparam logic [7:0] XSEL_BASE = 8'h80;
    localparam logic [7:0] BSEL_BASE = 8'h40;

    // Byte source for the nibble being emitted.
    typedef enum logic [1:0] {
        SRC_XSEL,
        SRC_BSEL,
        SRC_BYTE
    } src_t;

    // Framebuffer operation carried by a step.
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD,
        MEM_PIX,
        MEM_LOAD,
        MEM_ZERO
    } mem_t;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_END
    } seq_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sq_state_t;

    // One control word of the microprogram.
    typedef struct packed {
        src_t             src;
        logic             hi;
        logic             rs;
        mem_t             mem;
        seq_t             seq;
        logic [UPC_W-1:0] target;
    } uword_t;

    // Sequencer status handed to the datapath.
    typedef struct packed {
        logic   busy;
        uword_t word;
    } step_t;

    // Framebuffer access request.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [FB_AW-1:0] addr;
        logic [7:0]       wr_data;
    } fb_req_t;

    // Program entry points.
    localparam logic [UPC_W-1:0] UA_PIXEL   = 4'd0;
    localparam logic [UPC_W-1:0] UA_REFRESH = 4'd2;
    localparam logic [UPC_W-1:0] UA_ZERO    = 4'd4;
    localparam logic [UPC_W-1:0] UA_TAIL    = 4'd6;
    localparam logic [UPC_W-1:0] UA_CMDBYTE = 4'd10;
    localparam logic [UPC_W-1:0] UA_CHAR    = 4'd12;
    localparam logic [UPC_W-1:0] UA_NIBBLE  = 4'd14;

    function automatic uword_t uw(input src_t src, input logic hi, input logic rs,
                                  input mem_t mem, input seq_t seq,
                                  input logic [UPC_W-1:0] target);
        uword_t w;
        w.src    = src;
        w.hi     = hi;
        w.rs     = rs;
        w.mem    = mem;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    // Microprogram. Every step emits one nibble; column programs share a tail
    // that sends the bank select and the data byte.
    function automatic uword_t urom(input logic [UPC_W-1:0] a);
        uword_t w;
        unique case (a)
            4'd0:    w = uw(SRC_XSEL, 1'b1, 1'b0, MEM_RD,   SEQ_NEXT, UA_TAIL);
            4'd1:    w = uw(SRC_XSEL, 1'b0, 1'b0, MEM_PIX,  SEQ_JUMP, UA_TAIL);
            4'd2:    w = uw(SRC_XSEL, 1'b1, 1'b0, MEM_RD,   SEQ_NEXT, UA_TAIL);
            4'd3:    w = uw(SRC_XSEL, 1'b0, 1'b0, MEM_LOAD, SEQ_JUMP, UA_TAIL);
            4'd4:    w = uw(SRC_XSEL, 1'b1, 1'b0, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd5:    w = uw(SRC_XSEL, 1'b0, 1'b0, MEM_ZERO, SEQ_NEXT, UA_TAIL);
            4'd6:    w = uw(SRC_BSEL, 1'b1, 1'b0, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd7:    w = uw(SRC_BSEL, 1'b0, 1'b0, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd8:    w = uw(SRC_BYTE, 1'b1, 1'b1, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd9:    w = uw(SRC_BYTE, 1'b0, 1'b1, MEM_NONE, SEQ_END,  UA_TAIL);
            4'd10:   w = uw(SRC_BYTE, 1'b1, 1'b0, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd11:   w = uw(SRC_BYTE, 1'b0, 1'b0, MEM_NONE, SEQ_END,  UA_TAIL);
            4'd12:   w = uw(SRC_BYTE, 1'b1, 1'b1, MEM_NONE, SEQ_NEXT, UA_TAIL);
            4'd13:   w = uw(SRC_BYTE, 1'b0, 1'b1, MEM_NONE, SEQ_END,  UA_TAIL);
            4'd14:   w = uw(SRC_BYTE, 1'b0, 1'b0, MEM_NONE, SEQ_END,  UA_TAIL);
            default: w = uw(SRC_BYTE, 1'b0, 1'b0, MEM_NONE, SEQ_END,  UA_TAIL);
        endcase
        return w;
    endfunction

    // DDRAM offsets of the four text rows.
    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        unique case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/lnbg_fbuf.sv
// Column framebuffer: single memory with registered read and per-entry valid bits.
module lnbg_fbuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  lnbg_pkg::fb_req_t req,
    output logic [7:0]       rd_data
);

    logic [7:0]                  mem_reg [lnbg_pkg::FB_DEPTH];
    logic [lnbg_pkg::FB_DEPTH-1:0] valid_reg;
    logic [7:0]                  rd_mem_reg;
    logic                        rd_valid_reg;

    // Storage itself has no reset; an entry never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem_reg[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : 8'h00;

endmodule

### rtl/core/lnbg_useq.sv
// Microprogram sequencer: step counter, control word lookup and jumps.
module lnbg_useq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lnbg_pkg::UPC_W-1:0]    entry,
    input  logic                          adv,
    output lnbg_pkg::step_t               step
);

    lnbg_pkg::sq_state_t          state_reg;
    lnbg_pkg::sq_state_t          state_next;
    logic [lnbg_pkg::UPC_W-1:0]   upc_reg;
    logic [lnbg_pkg::UPC_W-1:0]   upc_next;
    lnbg_pkg::uword_t             word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lnbg_pkg::SQ_IDLE;
            upc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        word       = lnbg_pkg::urom(upc_reg);
        state_next = state_reg;
        upc_next   = upc_reg;
        if (start)
        begin
            state_next = lnbg_pkg::SQ_RUN;
            upc_next   = entry;
        end
        else
        begin
            unique case (state_reg)
                lnbg_pkg::SQ_IDLE:
                begin
                    state_next = lnbg_pkg::SQ_IDLE;
                end
                lnbg_pkg::SQ_RUN:
                begin
                    if (adv)
                    begin
                        unique case (word.seq)
                            lnbg_pkg::SEQ_NEXT: upc_next = upc_reg + 1'b1;
                            lnbg_pkg::SEQ_JUMP: upc_next = word.target;
                            lnbg_pkg::SEQ_END:  state_next = lnbg_pkg::SQ_IDLE;
                            default:            state_next = lnbg_pkg::SQ_IDLE;
                        endcase
                    end
                end
                default:
                begin
                    state_next = lnbg_pkg::SQ_IDLE;
                end
            endcase
        end
        step.busy = (state_reg == lnbg_pkg::SQ_RUN);
        step.word = word;
    end

`ifndef SYNTHESIS
    // A step that cannot emit keeps its place in the program.
    a_hold_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnbg_pkg::SQ_RUN && !adv) |=> $stable(upc_reg))
        else $error("step counter moved while the output was blocked");

    // The final step of a program returns the sequencer to idle.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnbg_pkg::SQ_RUN && adv && word.seq == lnbg_pkg::SEQ_END && !start)
        |=> (state_reg == lnbg_pkg::SQ_IDLE))
        else $error("sequencer kept running after its final step");

    // A started program begins at its entry point.
    a_start_entry: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == lnbg_pkg::SQ_RUN && upc_reg == $past(entry)))
        else $error("program did not start at its entry point");
`endif

endmodule

### rtl/core/lcd_nibble_bus_gfx_writer.sv
// Top level of the nibble-bus display writer: item capture, datapath and output register.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ---------------------------------------------
//  in       in_valid / in_stall     cmd, x, y, on, bank, row, col, value
//  out      out_valid / out_stall   rs, nibble, last
//
// Each accepted item runs a microprogram that emits one nibble per cycle unless the
// output stalls: six nibbles for a column command, two for cursor, character and
// command byte, one for a raw nibble. The next item is taken in the cycle that emits
// the last nibble. An item that gives no result (column out of range, unused code)
// is dropped. A stall on the output holds the program on its current step and stalls
// the input. Reset clears the control state and marks every framebuffer entry as zero.
module lcd_nibble_bus_gfx_writer
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [6:0] x,
    input  logic [3:0] y,
    input  logic       on,
    input  logic       bank,
    input  logic [1:0] row,
    input  logic [4:0] col,
    input  logic [7:0] value,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       rs,
    output logic [3:0] nibble,
    output logic       last
);

    lnbg_pkg::step_t                  step;
    lnbg_pkg::fb_req_t                fb_req;
    logic [7:0]                       fb_rd;

    logic                             accept;
    logic                             start;
    logic                             adv;
    logic                             last_step;
    logic                             item_ok;
    logic                             col_ok;
    logic                             row_ok;
    logic [lnbg_pkg::UPC_W-1:0]       entry;
    logic                             bank_in;
    logic [lnbg_pkg::FB_AW-1:0]       addr_in;
    logic [7:0]                       byte_in;

    // Captured item fields.
    logic [6:0]                       x_reg;
    logic                             bank_reg;
    logic [lnbg_pkg::FB_AW-1:0]       addr_reg;
    logic [2:0]                       ybit_reg;
    logic                             on_reg;
    logic [7:0]                       byte_reg;

    logic [7:0]                       mask;
    logic [7:0]                       pix_byte;
    logic [7:0]                       src_byte;
    logic [3:0]                       nib_sel;

    logic                             out_valid_reg;
    logic                             rs_reg;
    logic [3:0]                       nibble_reg;
    logic                             last_reg;

    lnbg_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .entry (entry),
        .adv   (adv),
        .step  (step)
    );

    lnbg_fbuf u_fbuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fb_req),
        .rd_data (fb_rd)
    );

    // Decode the incoming item: whether it produces output and where its
    // program starts. Column commands with an out-of-range column are dropped.
    always_comb
    begin
        col_ok = ({1'b0, x} < 8'(lnbg_pkg::COLUMNS));
        row_ok = ({1'b0, y} < 5'(lnbg_pkg::PIXEL_ROWS));
        unique case (cmd) inside
            lnbg_pkg::CMD_PIXEL:
            begin
                item_ok = col_ok && row_ok;
                entry   = lnbg_pkg::UA_PIXEL;
            end
            lnbg_pkg::CMD_REFRESH:
            begin
                item_ok = col_ok;
                entry   = lnbg_pkg::UA_REFRESH;
            end
            lnbg_pkg::CMD_ZERO:
            begin
                item_ok = col_ok;
                entry   = lnbg_pkg::UA_ZERO;
            end
            lnbg_pkg::CMD_CURSOR, lnbg_pkg::CMD_CMDBYTE:
            begin
                item_ok = 1'b1;
                entry   = lnbg_pkg::UA_CMDBYTE;
            end
            lnbg_pkg::CMD_CHAR:
            begin
                item_ok = 1'b1;
                entry   = lnbg_pkg::UA_CHAR;
            end
            lnbg_pkg::CMD_NIBBLE:
            begin
                item_ok = 1'b1;
                entry   = lnbg_pkg::UA_NIBBLE;
            end
            default:
            begin
                item_ok = 1'b0;
                entry   = lnbg_pkg::UA_PIXEL;
            end
        endcase

        // A pixel write takes its bank from the row; the other column
        // commands name it directly.
        bank_in = (cmd == lnbg_pkg::CMD_PIXEL) ? y[3] : bank;
        addr_in = bank_in ? lnbg_pkg::FB_AW'(lnbg_pkg::COLUMNS) + lnbg_pkg::FB_AW'(x)
                          : lnbg_pkg::FB_AW'(x);

        // Cursor moves become a set-address command byte, kept to 8 bits.
        if (cmd == lnbg_pkg::CMD_CURSOR)
        begin
            byte_in = lnbg_pkg::XSEL_BASE | (lnbg_pkg::row_base(row) + 8'(col));
        end
        else
        begin
            byte_in = value;
        end
    end

    // Every program step emits a nibble, so a step advances whenever the
    // output register is free or being emptied.
    assign adv       = step.busy && (!out_valid_reg || !out_stall);
    assign last_step = (step.word.seq == lnbg_pkg::SEQ_END);
    assign in_stall  = step.busy && !(adv && last_step);
    assign accept    = in_valid && !in_stall;
    assign start     = accept && item_ok;

    // Read-modify-write of the addressed column.
    assign mask     = 8'h01 << ybit_reg;
    assign pix_byte = on_reg ? (fb_rd | mask) : (fb_rd & ~mask);

    always_comb
    begin
        fb_req.rd_en   = adv && (step.word.mem == lnbg_pkg::MEM_RD);
        fb_req.wr_en   = adv && ((step.word.mem == lnbg_pkg::MEM_PIX) ||
                                 (step.word.mem == lnbg_pkg::MEM_ZERO));
        fb_req.addr    = addr_reg;
        fb_req.wr_data = (step.word.mem == lnbg_pkg::MEM_PIX) ? pix_byte : 8'h00;
    end

    always_comb
    begin
        unique case (step.word.src)
            lnbg_pkg::SRC_XSEL: src_byte = lnbg_pkg::XSEL_BASE | {1'b0, x_reg};
            lnbg_pkg::SRC_BSEL: src_byte = lnbg_pkg::BSEL_BASE | {7'b0, bank_reg};
            lnbg_pkg::SRC_BYTE: src_byte = byte_reg;
            default:            src_byte = byte_reg;
        endcase
        nib_sel = step.word.hi ? src_byte[7:4] : src_byte[3:0];
    end

    // Item capture. The byte register also receives the column data once the
    // framebuffer step of a column program has run.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x;
            bank_reg <= bank_in;
            addr_reg <= addr_in;
            ybit_reg <= y[2:0];
            on_reg   <= on;
            byte_reg <= byte_in;
        end
        else if (adv)
        begin
            case (step.word.mem)
                lnbg_pkg::MEM_PIX:  byte_reg <= pix_byte;
                lnbg_pkg::MEM_LOAD: byte_reg <= fb_rd;
                lnbg_pkg::MEM_ZERO: byte_reg <= 8'h00;
                default:            byte_reg <= byte_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg     <= step.word.rs;
            nibble_reg <= nib_sel;
            last_reg   <= last_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign rs        = rs_reg;
    assign nibble    = nibble_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // Taking an item while a program runs means the last nibble was just loaded into the output register.
    a_handover: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.busy) |=> (out_valid && last))
        else $error("item taken before the previous program finished");

    // A nibble that is not the last one always belongs to a running program.
    a_midprog: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |-> step.busy)
        else $error("program stopped before its last nibble");

    // A stalled output item stays on the bus unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable({rs, nibble, last})))
        else $error("output item changed while stalled");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the nibble-bus display writer with its column framebuffer.
module tb;

    // Code that the block must ignore, and the set-DDRAM-address prefix of a cursor move.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [7:0] DDRAM_SET  = 8'h80;

    // Text row start addresses of a four-line display.
    localparam logic [7:0] TEXT_ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Receiver hold-off length, in cycles, and the quiet-cycle watchdog limit.
    localparam int HOLD_CYCLES    = 90;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    // One nibble as it appears on the display bus.
    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } bus_nibble_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [2:0] cmd       = '0;
    logic [6:0] x         = '0;
    logic [3:0] y         = '0;
    logic       on        = 1'b0;
    logic       bank      = 1'b0;
    logic [1:0] row       = '0;
    logic [4:0] col       = '0;
    logic [7:0] value     = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       rs;
    logic [3:0] nibble;
    logic       last;

    // Nibbles the display should see next, oldest first, and our copy of the framebuffer.
    bus_nibble_t expected_nibbles [$];
    logic [7:0]  shadow_columns [lnbg_pkg::FB_DEPTH];

    // Traffic shaping knobs, owned by the test sequence.
    bit send_gaps_on  = 1'b1;
    bit stall_rand_on = 1'b1;
    int hold_reqs     = 0;

    // Bookkeeping for the summary and the verdict.
    int mismatches      = 0;
    int items_sent      = 0;
    int column_items    = 0;
    int text_items      = 0;
    int silent_items    = 0;
    int nibbles_checked = 0;
    int drain_pauses    = 0;
    int quiet_cycles    = 0;

    lcd_nibble_bus_gfx_writer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .x         (x),
        .y         (y),
        .on        (on),
        .bank      (bank),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rs        (rs),
        .nibble    (nibble),
        .last      (last)
    );

    // Period of 12 time units, six high and six low.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A byte always travels high nibble first; fin marks the closing nibble of an item.
    function automatic void queue_byte(input logic rs_lvl, input logic [7:0] data,
                                       input logic fin);
        expected_nibbles.push_back('{rs_lvl, data[7:4], 1'b0});
        expected_nibbles.push_back('{rs_lvl, data[3:0], fin});
    endfunction

    // A column goes out as column select, bank select, then the stored byte as data.
    function automatic void queue_column(input logic [6:0] xv, input logic b,
                                         input logic [7:0] data);
        queue_byte(1'b0, lnbg_pkg::XSEL_BASE | {1'b0, xv}, 1'b0);
        queue_byte(1'b0, lnbg_pkg::BSEL_BASE | {7'b0, b}, 1'b0);
        queue_byte(1'b1, data, 1'b1);
    endfunction

    // Updates the shadow framebuffer for one accepted item and queues the nibbles it causes.
    function automatic void predict_bus_nibbles(input logic [2:0] c, input logic [6:0] xv,
                                                input logic [3:0] yv, input logic o,
                                                input logic b, input logic [1:0] r,
                                                input logic [4:0] cl, input logic [7:0] v);
        int         idx;
        logic       pix_bank;
        logic [7:0] mask;
        logic [7:0] addr;
        case (c) inside
            lnbg_pkg::CMD_PIXEL:
            begin
                if (int'(xv) < lnbg_pkg::COLUMNS && int'(yv) < lnbg_pkg::PIXEL_ROWS)
                begin
                    pix_bank = yv[3];
                    mask     = 8'h01 << yv[2:0];
                    idx      = int'(pix_bank) * lnbg_pkg::COLUMNS + int'(xv);
                    if (o)
                        shadow_columns[idx] = shadow_columns[idx] | mask;
                    else
                        shadow_columns[idx] = shadow_columns[idx] & ~mask;
                    queue_column(xv, pix_bank, shadow_columns[idx]);
                    column_items++;
                end
                else
                    silent_items++;
            end
            lnbg_pkg::CMD_REFRESH, lnbg_pkg::CMD_ZERO:
            begin
                if (int'(xv) < lnbg_pkg::COLUMNS)
                begin
                    idx = int'(b) * lnbg_pkg::COLUMNS + int'(xv);
                    if (c == lnbg_pkg::CMD_ZERO)
                        shadow_columns[idx] = 8'h00;
                    queue_column(xv, b, shadow_columns[idx]);
                    column_items++;
                end
                else
                    silent_items++;
            end
            lnbg_pkg::CMD_CURSOR:
            begin
                // The sum wraps at eight bits, like the command byte on the bus.
                addr = TEXT_ROW_OFFSET[r] + {3'b000, cl};
                queue_byte(1'b0, DDRAM_SET | addr, 1'b1);
                text_items++;
            end
            lnbg_pkg::CMD_CHAR:
            begin
                queue_byte(1'b1, v, 1'b1);
                text_items++;
            end
            lnbg_pkg::CMD_CMDBYTE:
            begin
                queue_byte(1'b0, v, 1'b1);
                text_items++;
            end
            lnbg_pkg::CMD_NIBBLE:
            begin
                expected_nibbles.push_back('{1'b0, v[3:0], 1'b1});
                text_items++;
            end
            default:
                silent_items++;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offers one item from a falling edge, holds it until taken, and then maybe leaves a gap.
    // The payload stays put while the block stalls; valid is only lowered during a gap.
    task automatic send_item(input logic [2:0] c, input logic [6:0] xv, input logic [3:0] yv,
                             input logic o, input logic b, input logic [1:0] r,
                             input logic [4:0] cl, input logic [7:0] v);
        int gap;
        cmd      = c;
        x        = xv;
        y        = yv;
        on       = o;
        bank     = b;
        row      = r;
        col      = cl;
        value    = v;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_bus_nibbles(c, xv, yv, o, b, r, cl, v);
        items_sent++;
        @(negedge clk);
        if (send_gaps_on && $urandom_range(0, 99) < 23)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                // Junk on the payload while valid is low must be ignored.
                cmd   = 3'($urandom);
                x     = 7'($urandom);
                value = 8'($urandom);
                @(negedge clk);
            end
        end
    endtask

    // Picks a random item. Most are well formed, and about half of the column traffic
    // hits a handful of columns so that pixels pile up and refreshes carry real content.
    task automatic random_item();
        int         pick;
        int         xpick;
        logic [2:0] c;
        logic [6:0] xv;
        pick  = $urandom_range(0, 99);
        xpick = $urandom_range(0, 99);
        if (pick < 40)
            c = lnbg_pkg::CMD_PIXEL;
        else if (pick < 55)
            c = lnbg_pkg::CMD_REFRESH;
        else if (pick < 63)
            c = lnbg_pkg::CMD_ZERO;
        else if (pick < 71)
            c = lnbg_pkg::CMD_CURSOR;
        else if (pick < 79)
            c = lnbg_pkg::CMD_CHAR;
        else if (pick < 87)
            c = lnbg_pkg::CMD_CMDBYTE;
        else if (pick < 95)
            c = lnbg_pkg::CMD_NIBBLE;
        else
            c = CMD_UNUSED;
        if (xpick < 10)
            xv = 7'($urandom_range(lnbg_pkg::COLUMNS, 127));
        else if (xpick < 55)
            xv = 7'($urandom_range(0, 7));
        else
            xv = 7'($urandom_range(0, lnbg_pkg::COLUMNS - 1));
        send_item(c, xv, 4'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                  5'($urandom), 8'($urandom));
    endtask

    // Lowers valid and waits on falling edges until every queued nibble has been seen.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_nibbles.size() != 0)
            @(negedge clk);
    endtask

    // Pixel writes at the corners of the framebuffer, set and clear, and columns that
    // lie beyond the last one, which must produce nothing.
    task automatic test_pixel_extremes();
        send_item(lnbg_pkg::CMD_PIXEL, 7'd0,   4'd0,  1'b1, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd99,  4'd15, 1'b1, 1'b1, 2'd3, 5'd31, 8'hFF);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd99,  4'd8,  1'b1, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd99,  4'd15, 1'b0, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd50,  4'd3,  1'b1, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd50,  4'd12, 1'b1, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd100, 4'd0,  1'b1, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_PIXEL, 7'd127, 4'd7,  1'b1, 1'b1, 2'd3, 5'd31, 8'hFF);
        wait_drained();
    endtask

    // Refresh re-sends the stored byte, zero clears it first; both skip columns out of range.
    task automatic test_column_commands();
        send_item(lnbg_pkg::CMD_REFRESH, 7'd50,  4'd0, 1'b0, 1'b1, 2'd0, 5'd0, 8'h00);
        send_item(lnbg_pkg::CMD_REFRESH, 7'd50,  4'd0, 1'b0, 1'b0, 2'd0, 5'd0, 8'h00);
        send_item(lnbg_pkg::CMD_ZERO,    7'd50,  4'd0, 1'b0, 1'b1, 2'd0, 5'd0, 8'h00);
        send_item(lnbg_pkg::CMD_REFRESH, 7'd50,  4'd0, 1'b0, 1'b1, 2'd0, 5'd0, 8'h00);
        send_item(lnbg_pkg::CMD_REFRESH, 7'd127, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0, 8'h00);
        send_item(lnbg_pkg::CMD_ZERO,    7'd100, 4'd0, 1'b0, 1'b1, 2'd0, 5'd0, 8'h00);
        wait_drained();
    endtask

    // Cursor moves on every text row, including columns past the visible width,
    // plus characters, command bytes, raw nibbles and the unused code.
    task automatic test_text_commands();
        send_item(lnbg_pkg::CMD_CURSOR,  7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_CURSOR,  7'd0, 4'd0, 1'b0, 1'b0, 2'd1, 5'd19, 8'h00);
        send_item(lnbg_pkg::CMD_CURSOR,  7'd0, 4'd0, 1'b0, 1'b0, 2'd2, 5'd7,  8'h00);
        send_item(lnbg_pkg::CMD_CURSOR,  7'd0, 4'd0, 1'b0, 1'b0, 2'd3, 5'd31, 8'h00);
        send_item(lnbg_pkg::CMD_CHAR,    7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'h00);
        send_item(lnbg_pkg::CMD_CHAR,    7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'hFF);
        send_item(lnbg_pkg::CMD_CMDBYTE, 7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'h5A);
        send_item(lnbg_pkg::CMD_CMDBYTE, 7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'hA5);
        send_item(lnbg_pkg::CMD_NIBBLE,  7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'hF3);
        send_item(lnbg_pkg::CMD_NIBBLE,  7'd0, 4'd0, 1'b0, 1'b0, 2'd0, 5'd0,  8'h0C);
        send_item(CMD_UNUSED,            7'd5, 4'd5, 1'b1, 1'b1, 2'd1, 5'd1,  8'h33);
        wait_drained();
    endtask

    // Long random run with gaps on the input and stalls on the output.
    task automatic test_random_traffic();
        repeat (167)
            random_item();
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the block
    // fills up and has to stall its input.
    task automatic test_backpressure();
        hold_reqs++;
        send_gaps_on = 1'b0;
        repeat (24)
            random_item();
        send_gaps_on = 1'b1;
        wait_drained();
    endtask

    // The sender stops until the bus has gone quiet, then starts again.
    task automatic test_drain_pause();
        repeat (12)
            random_item();
        wait_drained();
        drain_pauses++;
        repeat (12)
            random_item();
        wait_drained();
    endtask

    // Back to back at full rate, with neither side idling.
    task automatic test_full_rate_burst();
        send_gaps_on  = 1'b0;
        stall_rand_on = 1'b0;
        repeat (80)
            random_item();
        wait_drained();
        send_gaps_on  = 1'b1;
        stall_rand_on = 1'b1;
    endtask

    // Receiver: random stalls, or a counted hold-off when the sequence asks for one.
    always @(negedge clk)
    begin : receiver
        static int hold_served = 0;
        static int hold_left   = 0;
        if (hold_reqs != hold_served)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (stall_rand_on)
            out_stall = ($urandom_range(0, 99) < 23);
        else
            out_stall = 1'b0;
    end

    // Each nibble taken off the bus is checked against the oldest one still expected.
    always @(posedge clk)
    begin
        bus_nibble_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_nibbles.size() == 0)
                report_mismatch($sformatf("unexpected nibble rs=%0b nibble=%h last=%0b",
                                          rs, nibble, last));
            else
            begin
                want = expected_nibbles.pop_front();
                if (rs !== want.rs)
                    report_mismatch($sformatf("rs got %0b want %0b (nibble #%0d)",
                                              rs, want.rs, nibbles_checked));
                if (nibble !== want.nibble)
                    report_mismatch($sformatf("nibble got %h want %h (nibble #%0d)",
                                              nibble, want.nibble, nibbles_checked));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b (nibble #%0d)",
                                              last, want.last, nibbles_checked));
            end
            nibbles_checked++;
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d nibbles still expected",
                     quiet_cycles, expected_nibbles.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_columns[i])
            shadow_columns[i] = 8'h00;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_pixel_extremes();
        test_column_commands();
        test_text_commands();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();
        test_full_rate_burst();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (expected_nibbles.size() != 0)
            report_mismatch($sformatf("%0d nibbles never arrived", expected_nibbles.size()));

        $display("covered %0d items: %0d column, %0d text, %0d ignored; %0d nibbles checked",
                 items_sent, column_items, text_items, silent_items, nibbles_checked);
        $display("included %0d receiver hold-off(s), %0d drained pause(s), %0d mismatches",
                 hold_reqs, drain_pauses, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
